// ===== sv/tvsm_pkg.sv =====
// shared constants and types for the three-voice square tone mixer
package tvsm_pkg;

  localparam int unsigned VOICES     = 3;
  localparam int unsigned VOICE_W    = 2;
  localparam int unsigned PERIOD_W   = 6;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned CTRL_W     = 2;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned SAMPLE_W   = 15;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [COUNT_W-1:0]  COUNT_MAX   = 7'd64;
  localparam logic [PERIOD_W-1:0] PERIOD_MASK = 6'h3f;
  localparam logic [CTRL_W-1:0]   CTRL_MASK   = 2'h3;

  localparam logic [SAMPLE_W-1:0] WEIGHT_0 = 15'h1000;
  localparam logic [SAMPLE_W-1:0] WEIGHT_1 = 15'h1800;
  localparam logic [SAMPLE_W-1:0] WEIGHT_2 = 15'h2000;

  // operation codes carried on tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // register map
  localparam logic [1:0] REG_VOICE0 = 2'd0;
  localparam logic [1:0] REG_VOICE1 = 2'd1;
  localparam logic [1:0] REG_VOICE2 = 2'd2;
  localparam logic [1:0] REG_CTRL   = 2'd3;

  // mix control bits
  localparam int unsigned CTRL_XOR_BIT    = 0;
  localparam int unsigned CTRL_ENABLE_BIT = 1;

  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

// ===== sv/three_voice_square_tone_mixer.sv =====
// top level of the three-voice square tone mixer
//
// three square-wave voices behind four byte registers. every input item is
// either a register write (tuser = 0) or a sample tick (tuser = 1). a write
// to registers 0..2 stores the inverted low six data bits as that voice's
// period; writing a period that decodes to zero over a nonzero one flips the
// voice once and stalls it. a write to register 3 keeps data bits 1..0 as the
// mix control. a tick steps all three counters (saturating at 64), toggles
// every voice whose counter reaches its nonzero period, and returns one
// 15-bit unsigned mixed sample; a write returns nothing. an item waits in the
// input register, and the voice update is combinational between that
// register and the output register, so a tick's sample is offered from the
// output register once the tick leaves the input register. one item is taken
// per clock while the result side keeps up; a stalled result only blocks
// ticks, since writes need no output slot.
module three_voice_square_tone_mixer (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] reg_index, [9:2] write_data, rest zero
  input  logic        in_tuser,   // [0] operation
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [14:0] mixed_sample, rest zero
);

  // input register stage
  logic                          s1_valid_r;
  logic                          s1_op_r;
  logic [1:0]                    s1_idx_r;
  logic [tvsm_pkg::DATA_W-1:0]   s1_data_r;
  logic                          s1_adv;
  logic                          in_acc;

  // voice state
  tvsm_pkg::count_t              count_r  [tvsm_pkg::VOICES];
  tvsm_pkg::count_t              count_nxt[tvsm_pkg::VOICES];
  tvsm_pkg::period_t             period_r  [tvsm_pkg::VOICES];
  tvsm_pkg::period_t             period_nxt[tvsm_pkg::VOICES];
  logic [tvsm_pkg::VOICES-1:0]   level_r;
  logic [tvsm_pkg::VOICES-1:0]   level_nxt;
  logic [tvsm_pkg::CTRL_W-1:0]   ctrl_r;
  logic [tvsm_pkg::CTRL_W-1:0]   ctrl_nxt;

  // output register
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  tvsm_pkg::sample_t             sample_r;
  tvsm_pkg::sample_t             sample_nxt;

  tvsm_pkg::period_t             wr_period;
  tvsm_pkg::count_t              step;
  logic                          l0, l1, l2;
  logic                          m0, m1;

  // the update stage moves on unless a tick finds the output slot full and not being taken
  assign s1_adv    = s1_valid_r &&
                     (s1_op_r == tvsm_pkg::OP_WRITE || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_tuser;
      s1_idx_r  <= in_tdata[1:0];
      s1_data_r <= in_tdata[9:2];
    end
  end

  // period registers hold the inverted low data bits
  assign wr_period = (~s1_data_r[tvsm_pkg::PERIOD_W-1:0]) & tvsm_pkg::PERIOD_MASK;

  always_comb begin
    for (int i = 0; i < tvsm_pkg::VOICES; i++) begin
      count_nxt[i]  = count_r[i];
      period_nxt[i] = period_r[i];
      level_nxt[i]  = level_r[i];
    end
    ctrl_nxt = ctrl_r;
    step     = '0;

    if (s1_adv) begin
      if (s1_op_r == tvsm_pkg::OP_WRITE) begin
        if (s1_idx_r == tvsm_pkg::REG_CTRL) begin
          ctrl_nxt = s1_data_r[tvsm_pkg::CTRL_W-1:0] & tvsm_pkg::CTRL_MASK;
        end else begin
          for (int i = 0; i < tvsm_pkg::VOICES; i++) begin
            if (s1_idx_r == tvsm_pkg::VOICE_W'(i)) begin
              // zero period over a running voice flips it once
              if (wr_period == '0 && period_r[i] != '0) begin
                level_nxt[i] = ~level_r[i];
              end
              period_nxt[i] = wr_period;
            end
          end
        end
      end else begin
        // sample tick: each voice steps on its own
        for (int i = 0; i < tvsm_pkg::VOICES; i++) begin
          if (count_r[i] < tvsm_pkg::COUNT_MAX) begin
            step = count_r[i] + tvsm_pkg::count_t'(1);
          end else begin
            step = count_r[i];
          end
          if (period_r[i] != '0 &&
              step >= tvsm_pkg::count_t'(period_r[i])) begin
            count_nxt[i] = '0;
            level_nxt[i] = ~level_r[i];
          end else begin
            count_nxt[i] = step;
          end
        end
      end
    end
  end

  // mixing uses the levels after this tick's toggles
  assign l0 = level_nxt[0];
  assign l1 = level_nxt[1];
  assign l2 = level_nxt[2];
  assign m0 = ctrl_r[tvsm_pkg::CTRL_XOR_BIT] ? (l0 ^ l1) : l0;
  assign m1 = ctrl_r[tvsm_pkg::CTRL_XOR_BIT] ? (l1 ^ l2) : l1;

  always_comb begin
    if (ctrl_r[tvsm_pkg::CTRL_ENABLE_BIT]) begin
      sample_nxt = (m0 ? tvsm_pkg::WEIGHT_0 : '0) +
                   (m1 ? tvsm_pkg::WEIGHT_1 : '0) +
                   (l2 ? tvsm_pkg::WEIGHT_2 : '0);
    end else begin
      sample_nxt = '0;
    end
  end

  // output slot: filled by a tick, emptied when taken
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (s1_adv && s1_op_r == tvsm_pkg::OP_TICK) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tvsm_pkg::VOICES; i++) begin
        count_r[i]  <= '0;
        period_r[i] <= '0;
      end
      level_r     <= '1;
      ctrl_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < tvsm_pkg::VOICES; i++) begin
        count_r[i]  <= count_nxt[i];
        period_r[i] <= period_nxt[i];
      end
      level_r     <= level_nxt;
      ctrl_r      <= ctrl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_op_r == tvsm_pkg::OP_TICK) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(tvsm_pkg::OUT_TDATA_W - tvsm_pkg::SAMPLE_W){1'b0}}, sample_r};

endmodule

// ===== tb/sv/three_voice_square_tone_mixer_test.sv =====
// self-checking testbench for the three-voice square tone mixer
`timescale 1ns / 100ps

module three_voice_square_tone_mixer_test;

  // no item accepted on either side for this many cycles ends the run
  localparam int unsigned ACCEPT_TIMEOUT = 3000;
  // one long receiver hold-off so the block backs up into its input
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned RANDOM_BURSTS  = 29;
  localparam int unsigned BURST_ITEMS    = 50;
  localparam int unsigned PRINT_CAP      = 100;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [tvsm_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [tvsm_pkg::OUT_TDATA_W-1:0] out_tdata;

  three_voice_square_tone_mixer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // directed rows: a pinned row carries its sample typed in, the rest
  // take the sample worked out by the voice model below
  typedef struct packed {
    logic              op;
    logic [1:0]        reg_sel;
    logic [7:0]        data;
    logic              pinned;
    tvsm_pkg::sample_t sample;
  } stim_row_t;

  localparam int unsigned DIRECTED_ROWS = 25;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{tvsm_pkg::OP_TICK,  tvsm_pkg::REG_VOICE0, 8'h00, 1'b1, 15'h0000}, // mix disabled after reset
    '{tvsm_pkg::OP_WRITE, tvsm_pkg::REG_CTRL,   8'hfe, 1'b0, 15'h0000}, // upper bits dropped
    '{tvsm_pkg::OP_TICK,  tvsm_pkg::REG_VOICE0, 8'h00, 1'b1, 15'h4800}, // all three levels high
    '{tvsm_pkg::OP_WRITE, tvsm_pkg::REG_CTRL,   8'h03, 1'b0, 15'h0000}, // enable with xor pairs
    '{tvsm_pkg::OP_TICK,  tvsm_pkg::REG_VOICE0, 8'h00, 1'b1, 15'h2000}, // pairs cancel
    '{tvsm_pkg::OP_WRITE, tvsm_pkg::REG_VOICE0, 8'h3e, 1'b0, 15'h0000}, // shortest period
    '{tvsm_pkg::OP_WRITE, tvsm_pkg::REG_VOICE1, 8'hc0, 1'b0, 15'h0000}, // longest, high bits
    '{tvsm_pkg::OP_WRITE, tvsm_pkg::REG_VOICE2, 8'h00, 1'b0, 15'h0000}, // longest period
    '{tvsm_pkg::OP_TICK,  tvsm_pkg::REG_VOICE0, 8'h00, 1'b0, 15'h0000},
    '{tvsm_pkg::OP_TICK,  tvsm_pkg::REG_VOICE2, 8'hff, 1'b0, 15'h0000}, // tick ignores its data
    '{tvsm_pkg::OP_WRITE, tvsm_pkg::REG_VOICE0, 8'hff, 1'b0, 15'h0000}, // zero over nonzero
    '{tvsm_pkg::OP_TICK,  tvsm_pkg::REG_VOICE0, 8'h00, 1'b0, 15'h0000},
    '{tvsm_pkg::OP_WRITE, tvsm_pkg::REG_VOICE0, 8'h3f, 1'b0, 15'h0000}, // zero over zero
    '{tvsm_pkg::OP_TICK,  tvsm_pkg::REG_VOICE0, 8'h00, 1'b0, 15'h0000},
    '{tvsm_pkg::OP_WRITE, tvsm_pkg::REG_VOICE1, 8'h3e, 1'b0, 15'h0000}, // period below count
    '{tvsm_pkg::OP_TICK,  tvsm_pkg::REG_VOICE0, 8'h00, 1'b0, 15'h0000},
    '{tvsm_pkg::OP_WRITE, tvsm_pkg::REG_CTRL,   8'h00, 1'b0, 15'h0000},
    '{tvsm_pkg::OP_TICK,  tvsm_pkg::REG_VOICE0, 8'h00, 1'b1, 15'h0000}, // mix off
    '{tvsm_pkg::OP_WRITE, tvsm_pkg::REG_CTRL,   8'h02, 1'b0, 15'h0000}, // plain weighted mix
    '{tvsm_pkg::OP_TICK,  tvsm_pkg::REG_VOICE0, 8'h00, 1'b0, 15'h0000},
    '{tvsm_pkg::OP_WRITE, tvsm_pkg::REG_CTRL,   8'h01, 1'b0, 15'h0000}, // xor bit, no enable
    '{tvsm_pkg::OP_TICK,  tvsm_pkg::REG_VOICE1, 8'h55, 1'b1, 15'h0000},
    '{tvsm_pkg::OP_WRITE, tvsm_pkg::REG_CTRL,   8'hff, 1'b0, 15'h0000},
    '{tvsm_pkg::OP_WRITE, tvsm_pkg::REG_VOICE2, 8'hff, 1'b0, 15'h0000}, // stall voice 2
    '{tvsm_pkg::OP_TICK,  tvsm_pkg::REG_VOICE0, 8'h00, 1'b0, 15'h0000}
  };

  // voice model state
  tvsm_pkg::count_t  voice_count [tvsm_pkg::VOICES];
  tvsm_pkg::period_t voice_period [tvsm_pkg::VOICES];
  logic              voice_level [tvsm_pkg::VOICES];
  logic [1:0]        mix_ctrl;

  tvsm_pkg::sample_t expected_samples [$];
  logic              pinned_valid;
  tvsm_pkg::sample_t pinned_sample;

  int unsigned mismatch_count;
  int unsigned samples_checked;
  int unsigned quiet_cycles;
  bit          quiet_phase;
  bit          pressure_done;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch %s: got %h, want %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // voice model: follows every item accepted on the input side
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : voice_model
    tvsm_pkg::count_t  c;
    tvsm_pkg::period_t per;
    tvsm_pkg::sample_t mix;
    logic              l0, l1, l2;
    logic [1:0]        reg_sel;
    logic [7:0]        wdata;
    if (!rst_n) begin
      for (int v = 0; v < tvsm_pkg::VOICES; v++) begin
        voice_count[v]  = '0;
        voice_period[v] = '0;
        voice_level[v]  = 1'b1;
      end
      mix_ctrl = '0;
    end else if (in_tvalid && in_tready) begin
      reg_sel = in_tdata[tvsm_pkg::VOICE_W-1:0];
      wdata   = in_tdata[tvsm_pkg::VOICE_W +: tvsm_pkg::DATA_W];
      if (in_tuser == tvsm_pkg::OP_WRITE) begin
        if (reg_sel == tvsm_pkg::REG_CTRL) begin
          mix_ctrl = wdata[tvsm_pkg::CTRL_W-1:0] & tvsm_pkg::CTRL_MASK;
        end else begin
          // periods are stored inverted; zero over nonzero flips the level
          per = ~wdata[tvsm_pkg::PERIOD_W-1:0] & tvsm_pkg::PERIOD_MASK;
          if (per == '0 && voice_period[reg_sel] != '0)
            voice_level[reg_sel] = ~voice_level[reg_sel];
          voice_period[reg_sel] = per;
        end
      end else begin
        for (int v = 0; v < tvsm_pkg::VOICES; v++) begin
          c = voice_count[v];
          if (c < tvsm_pkg::COUNT_MAX)
            c = c + 1'b1;
          if (voice_period[v] != '0 && c >= tvsm_pkg::count_t'(voice_period[v])) begin
            c = '0;
            voice_level[v] = ~voice_level[v];
          end
          voice_count[v] = c;
        end
        l0  = voice_level[0];
        l1  = voice_level[1];
        l2  = voice_level[2];
        mix = '0;
        if (mix_ctrl[tvsm_pkg::CTRL_ENABLE_BIT]) begin
          if (mix_ctrl[tvsm_pkg::CTRL_XOR_BIT])
            mix = ((l0 ^ l1) ? tvsm_pkg::WEIGHT_0 : '0) +
                  ((l1 ^ l2) ? tvsm_pkg::WEIGHT_1 : '0);
          else
            mix = (l0 ? tvsm_pkg::WEIGHT_0 : '0) + (l1 ? tvsm_pkg::WEIGHT_1 : '0);
          mix = mix + (l2 ? tvsm_pkg::WEIGHT_2 : '0);
        end
        expected_samples.push_back(pinned_valid ? pinned_sample : mix);
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : sample_checker
    tvsm_pkg::sample_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("sample with nothing expected", out_tdata, '0);
      end else begin
        want = expected_samples.pop_front();
        if (out_tdata !== {{(tvsm_pkg::OUT_TDATA_W-tvsm_pkg::SAMPLE_W){1'b0}}, want})
          report_mismatch("mixed_sample", out_tdata,
                          {{(tvsm_pkg::OUT_TDATA_W-tvsm_pkg::SAMPLE_W){1'b0}}, want});
      end
      samples_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: cycles with no item moving on either side
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= ACCEPT_TIMEOUT);
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // result side: random stalls, plus one long hold once samples flow
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned r;
    out_tready    = 1'b0;
    stall_left    = 0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressure_done && samples_checked >= 200) begin
        pressure_done = 1'b1;
        stall_left    = HOLD_CYCLES;
      end else if (stall_left == 0 && !quiet_phase) begin
        r = $urandom_range(99);
        if (r < 70)
          stall_left = 0;
        else if (r < 92)
          stall_left = $urandom_range(1, 3);
        else if (r < 98)
          stall_left = $urandom_range(4, 12);
        else
          stall_left = $urandom_range(20, 60);
      end
      out_tready <= (stall_left == 0) && rst_n;
      if (stall_left != 0)
        stall_left--;
    end
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  task automatic send_item(input logic op, input logic [1:0] reg_sel,
                           input logic [7:0] data, input logic pin,
                           input tvsm_pkg::sample_t pin_sample);
    @(negedge clk);
    in_tvalid     <= 1'b1;
    in_tuser      <= op;
    in_tdata      <= {{(tvsm_pkg::IN_TDATA_W-tvsm_pkg::VOICE_W-tvsm_pkg::DATA_W){1'b0}},
                      data, reg_sel};
    pinned_valid  = pin;
    pinned_sample = pin_sample;
    do @(posedge clk); while (!in_tready);
  endtask

  // sender gap: mostly none or short, now and then long
  task automatic pause_sender();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    if (quiet_phase || r < 55)
      n = 0;
    else if (r < 90)
      n = $urandom_range(1, 3);
    else if (r < 98)
      n = $urandom_range(4, 12);
    else
      n = $urandom_range(20, 60);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  initial begin : stimulus
    logic [1:0]  reg_sel;
    logic [7:0]  data;
    int unsigned write_pct;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tuser       = tvsm_pkg::OP_WRITE;
    in_tdata       = '0;
    pinned_valid   = 1'b0;
    pinned_sample  = '0;
    mismatch_count = 0;
    quiet_phase    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(DIRECTED[i].op, DIRECTED[i].reg_sel, DIRECTED[i].data,
                DIRECTED[i].pinned, DIRECTED[i].sample);
      pause_sender();
    end

    // random bursts; the write rate changes per burst so that some bursts
    // leave periods alone long enough for counters to reach saturation
    for (int b = 0; b < RANDOM_BURSTS; b++) begin
      case ($urandom_range(2))
        0: write_pct = 2;
        1: write_pct = 10;
        default: write_pct = 40;
      endcase
      quiet_phase = ($urandom_range(3) == 0);
      for (int k = 0; k < BURST_ITEMS; k++) begin
        if ($urandom_range(99) < write_pct) begin
          reg_sel = 2'($urandom_range(3));
          data    = 8'($urandom);
          if (reg_sel == tvsm_pkg::REG_CTRL) begin
            data[tvsm_pkg::CTRL_ENABLE_BIT] = ($urandom_range(3) != 0);
          end else if ($urandom_range(4) == 0) begin
            data[tvsm_pkg::PERIOD_W-1:0] = tvsm_pkg::PERIOD_MASK;  // zero period
          end else if ($urandom_range(2) == 0) begin
            // short period
            data[tvsm_pkg::PERIOD_W-1:0] = ~tvsm_pkg::period_t'($urandom_range(1, 4));
          end
          send_item(tvsm_pkg::OP_WRITE, reg_sel, data, 1'b0, '0);
        end else begin
          // ticks carry random bits in the unused fields
          send_item(tvsm_pkg::OP_TICK, 2'($urandom), 8'($urandom), 1'b0, '0);
        end
        pause_sender();
      end
    end
    quiet_phase = 1'b0;

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tvsm_pkg.sv
sv/three_voice_square_tone_mixer.sv
tb/sv/three_voice_square_tone_mixer_test.sv
